@@ src/sma_pkg.sv @@
package sma_pkg;

	// Field widths of the request, the result and the registers.
	localparam int SizeW = 24;
	localparam int AddrW = 32;
	localparam int StatusW = 2;
	localparam int CfgIndexW = 1;
	localparam int CfgDataW = 32;

	// Default depth of the block table.
	localparam int TableEntriesDefault = 24;

	// Request opcodes.
	localparam logic CmdAlloc = 1'b0;
	localparam logic CmdFree = 1'b1;

	// Result status codes.
	localparam logic [StatusW-1:0] StOk = 2'd0;
	localparam logic [StatusW-1:0] StHeapFull = 2'd1;
	localparam logic [StatusW-1:0] StTableFull = 2'd2;
	localparam logic [StatusW-1:0] StNotFound = 2'd3;

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] CfgHeapBase = 1'd0;
	localparam logic [CfgIndexW-1:0] CfgHeapLimit = 1'd1;

	typedef struct packed {
		logic cmd;
		logic [SizeW-1:0] request_size;
		logic [AddrW-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [AddrW-1:0] block_address;
		logic reused;
		logic [StatusW-1:0] status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;
		logic scan_done;
	} dp_stat_t;

endpackage

@@ src/sma_stream_if.sv @@
interface sma_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/sma_ram.sv @@
module sma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/sma_ctrl.sv @@
module sma_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input sma_pkg::dp_stat_t stat,
	output sma_pkg::ctl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic out_valid_q;
	logic out_free;

	// The result register may be refilled in the cycle its old item leaves.
	assign out_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.match || stat.scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A commit waits while the previous result is still held.
	a_commit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && !out_free) |=> (state_q == S_COMMIT))
		else $error("commit left before the result register was free");

	// Every commit presents its result in the next cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed item did not reach the output");

endmodule

@@ src/sma_dp.sv @@
module sma_dp #(
	parameter int TABLE_ENTRIES = sma_pkg::TableEntriesDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sma_pkg::CfgIndexW-1:0] cfg_index,
	input logic [sma_pkg::CfgDataW-1:0] cfg_data,
	input sma_pkg::req_t req_data,
	input sma_pkg::ctl_cmd_t cmd,
	output sma_pkg::dp_stat_t stat,
	output sma_pkg::rsp_t result
);

	localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CntW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CntW-1:0] FullCount = CntW'(TABLE_ENTRIES);

	// Heap registers and table bookkeeping.
	logic [sma_pkg::SizeW-1:0] heap_limit_q;
	logic [sma_pkg::AddrW-1:0] next_addr_q;
	logic [sma_pkg::SizeW-1:0] heap_used_q;
	logic [CntW-1:0] filled_q;
	logic [TABLE_ENTRIES-1:0] in_use_q;

	// Request being worked on.
	logic op_q;
	logic [sma_pkg::SizeW-1:0] size_q;
	logic [sma_pkg::AddrW-1:0] free_addr_q;

	// Scan state.
	logic [CntW-1:0] rd_idx_q;
	logic pend_s1;
	logic [IdxW-1:0] cmp_idx_s1;
	logic hit_q;
	logic [IdxW-1:0] hit_idx_q;
	logic [sma_pkg::AddrW-1:0] hit_addr_q;

	// Result register.
	sma_pkg::rsp_t result_q;

	logic [sma_pkg::SizeW-1:0] size_rd;
	logic [sma_pkg::AddrW-1:0] addr_rd;
	logic issue;
	logic match;
	logic [sma_pkg::SizeW:0] used_sum;
	logic fits;
	logic room;
	logic do_fresh;
	logic ram_we;
	sma_pkg::rsp_t res_d;

	assign ram_we = cmd.commit && do_fresh;

	sma_ram #(.WIDTH(sma_pkg::SizeW), .DEPTH(TABLE_ENTRIES)) u_size_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(filled_q[IdxW-1:0]),
		.wdata(size_q),
		.raddr(rd_idx_q[IdxW-1:0]),
		.rdata(size_rd)
	);

	sma_ram #(.WIDTH(sma_pkg::AddrW), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(filled_q[IdxW-1:0]),
		.wdata(next_addr_q),
		.raddr(rd_idx_q[IdxW-1:0]),
		.rdata(addr_rd)
	);

	// One entry is read per cycle and compared in the cycle after its read.
	assign issue = cmd.scan && (rd_idx_q < filled_q);

	always_comb begin
		if (op_q == sma_pkg::CmdFree) begin
			match = pend_s1 && (addr_rd == free_addr_q);
		end else begin
			match = pend_s1 && !in_use_q[cmp_idx_s1] && (size_rd == size_q);
		end
	end

	assign stat.match = match;
	assign stat.scan_done = (rd_idx_q >= filled_q) && !match;

	assign used_sum = {1'b0, heap_used_q} + {1'b0, size_q};
	assign fits = (used_sum <= {1'b0, heap_limit_q});
	assign room = (filled_q != FullCount);

	always_comb begin
		res_d = '0;
		res_d.status = sma_pkg::StOk;
		do_fresh = 1'b0;
		if (op_q == sma_pkg::CmdAlloc) begin
			priority if (hit_q) begin
				res_d.block_address = hit_addr_q;
				res_d.reused = 1'b1;
			end else if (!fits) begin
				res_d.status = sma_pkg::StHeapFull;
			end else if (!room) begin
				res_d.status = sma_pkg::StTableFull;
			end else begin
				res_d.block_address = next_addr_q;
				do_fresh = 1'b1;
			end
		end else if (!hit_q) begin
			res_d.status = sma_pkg::StNotFound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= sma_pkg::SizeW'(65536);
			next_addr_q <= '0;
			heap_used_q <= '0;
			filled_q <= '0;
			in_use_q <= '0;
			rd_idx_q <= '0;
			pend_s1 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sma_pkg::CfgHeapBase: begin
						// The base only matters as the seed of the bump pointer.
						if (filled_q == '0) begin
							next_addr_q <= cfg_data;
						end
					end
					sma_pkg::CfgHeapLimit: begin
						heap_limit_q <= cfg_data[sma_pkg::SizeW-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				rd_idx_q <= '0;
				pend_s1 <= 1'b0;
				hit_q <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (do_fresh) begin
					in_use_q[filled_q[IdxW-1:0]] <= 1'b1;
					filled_q <= filled_q + 1'b1;
					next_addr_q <= next_addr_q + {{(sma_pkg::AddrW - sma_pkg::SizeW){1'b0}}, size_q};
					heap_used_q <= used_sum[sma_pkg::SizeW-1:0];
				end else if (hit_q) begin
					in_use_q[hit_idx_q] <= (op_q == sma_pkg::CmdAlloc);
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req_data.cmd;
			size_q <= req_data.request_size;
			free_addr_q <= req_data.free_address;
		end
		if (issue) begin
			cmp_idx_s1 <= rd_idx_q[IdxW-1:0];
		end
		if (cmd.scan && match) begin
			hit_idx_q <= cmp_idx_s1;
			hit_addr_q <= addr_rd;
		end
		if (cmd.commit) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

	// The fill count never passes the table depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FullCount)
		else $error("table fill count beyond depth");

	// Heap use and fill count move only when an item commits.
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> ($stable(heap_used_q) && $stable(filled_q)))
		else $error("heap state changed outside a commit");

endmodule

@@ src/size_match_reuse_allocator.sv @@
// Size-matching allocator with a reuse table.
//
// Items arrive on req (cmd, request_size, free_address) and one result item
// per request leaves on rsp (block_address, reused, status). Both channels
// use valid/ready; an item moves at a clock edge where both are high.
// The configuration port writes heap_base (index 0) or heap_limit (index 1)
// whenever cfg_we is high; it is meant to be used only while no request is
// in flight. Writing heap_base before any block is handed out also moves the
// bump pointer.
//
// Timing: a request scans the filled table entries one per cycle through
// the registered read port of the entry memories, stopping at the first
// match; at most TABLE_ENTRIES entries are ever filled. After the scan the
// commit step writes the result register and the controller returns to
// idle, and only there is the next request taken, so a new request is not
// accepted before the previous one has committed.
//
// A finished result sits in an output register; the next request is
// accepted while it waits, but its commit holds until rsp takes the old one.
// Reset (arst_n low) empties the table, clears heap use and sets heap_base
// to 0 and heap_limit to 65536. No clearing pass is needed afterward.
module size_match_reuse_allocator #(
	parameter int TABLE_ENTRIES = sma_pkg::TableEntriesDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sma_pkg::CfgIndexW-1:0] cfg_index,
	input logic [sma_pkg::CfgDataW-1:0] cfg_data,
	sma_stream_if.sink req,
	sma_stream_if.source rsp
);

	sma_pkg::ctl_cmd_t cmd;
	sma_pkg::dp_stat_t stat;
	sma_pkg::rsp_t result;
	sma_pkg::req_t req_data;

	assign req_data = req.data;

	// The controller sequences load, scan and commit of each item.
	sma_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.stat(stat),
		.cmd(cmd)
	);

	// The datapath holds the table, the heap pointers and the result.
	sma_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_data(req_data),
		.cmd(cmd),
		.stat(stat),
		.result(result)
	);

	assign rsp.data = result;

endmodule

@@ bench/tb_size_match_reuse_allocator.sv @@
`timescale 1ns / 100ps

module tb_size_match_reuse_allocator;

	// Depth of the block table in the instance below.
	localparam int TABLE_DEPTH = sma_pkg::TableEntriesDefault;
	// Cycles with no item moving on either channel before the run is given up.
	// One request scans at most TABLE_DEPTH entries, and the random gaps and
	// stalls add short runs on top, so this is many times the worst case.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed after the last expected result for a stray one to show up.
	localparam int DRAIN_CYCLES = 40;

	// The scoreboard keeps its own copy of the allocator: the table, the bump
	// pointer, the used-byte count and both registers. Every accepted request
	// is run through that copy at once, and the result it should produce is
	// queued until the block delivers one.
	class alloc_tracker;
		logic [sma_pkg::AddrW-1:0] heap_base;
		logic [sma_pkg::SizeW-1:0] heap_limit;
		logic [sma_pkg::AddrW-1:0] next_address;
		logic [sma_pkg::SizeW-1:0] heap_used;
		bit in_use[TABLE_DEPTH];
		logic [sma_pkg::SizeW-1:0] blk_size[TABLE_DEPTH];
		logic [sma_pkg::AddrW-1:0] blk_addr[TABLE_DEPTH];
		int filled;
		sma_pkg::rsp_t expected_grants[$];
		int errors;

		function new();
			heap_base = '0;
			heap_limit = 24'd65536;
			next_address = '0;
			heap_used = '0;
			filled = 0;
			errors = 0;
			foreach (in_use[i]) in_use[i] = 1'b0;
		endfunction

		function void write_reg(logic [sma_pkg::CfgIndexW-1:0] idx,
				logic [sma_pkg::CfgDataW-1:0] val);
			if (idx == sma_pkg::CfgHeapBase) begin
				heap_base = val;
				// The pointer only follows the base while the table is empty.
				if (filled == 0) next_address = val;
			end else begin
				heap_limit = val[sma_pkg::SizeW-1:0];
			end
		endfunction

		function void note_request(sma_pkg::req_t r);
			sma_pkg::rsp_t g;
			bit found;
			logic [sma_pkg::SizeW:0] total;
			g = '0;
			found = 1'b0;
			if (r.cmd == sma_pkg::CmdAlloc) begin
				// An exact-size block that was freed earlier is handed out again.
				for (int i = 0; i < filled && !found; i++) begin
					if (!in_use[i] && blk_size[i] == r.request_size) begin
						in_use[i] = 1'b1;
						g.block_address = blk_addr[i];
						g.reused = 1'b1;
						g.status = sma_pkg::StOk;
						found = 1'b1;
					end
				end
				if (!found) begin
					// The heap check comes before the table check.
					total = {1'b0, heap_used} + {1'b0, r.request_size};
					if (total > {1'b0, heap_limit}) begin
						g.status = sma_pkg::StHeapFull;
					end else if (filled >= TABLE_DEPTH) begin
						g.status = sma_pkg::StTableFull;
					end else begin
						in_use[filled] = 1'b1;
						blk_size[filled] = r.request_size;
						blk_addr[filled] = next_address;
						filled++;
						g.block_address = next_address;
						g.status = sma_pkg::StOk;
						next_address = next_address + {8'd0, r.request_size};
						heap_used = total[sma_pkg::SizeW-1:0];
					end
				end
			end else begin
				// A free acts on the lowest entry holding the address.
				for (int i = 0; i < filled && !found; i++) begin
					if (blk_addr[i] == r.free_address) begin
						in_use[i] = 1'b0;
						found = 1'b1;
					end
				end
				g.status = found ? sma_pkg::StOk : sma_pkg::StNotFound;
			end
			expected_grants.push_back(g);
		endfunction

		function void check_response(sma_pkg::rsp_t got);
			sma_pkg::rsp_t want;
			if (expected_grants.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: block_address %h reused %0d status %0d",
						got.block_address, got.reused, got.status);
				errors++;
				return;
			end
			want = expected_grants.pop_front();
			if (got.block_address !== want.block_address || got.reused !== want.reused ||
					got.status !== want.status) begin
				if (errors < 10)
					$display("mismatch: block_address %h/%h reused %0d/%0d status %0d/%0d",
						want.block_address, got.block_address, want.reused, got.reused,
						want.status, got.status);
				errors++;
			end
		endfunction

		// An address that some filled entry holds, so that most frees hit.
		function logic [sma_pkg::AddrW-1:0] pick_address();
			if (filled == 0) return $urandom;
			return blk_addr[$urandom_range(0, filled - 1)];
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sma_pkg::CfgIndexW-1:0] cfg_index;
	logic [sma_pkg::CfgDataW-1:0] cfg_data;

	sma_stream_if #(.payload_t(sma_pkg::req_t)) req_if ();
	sma_stream_if #(.payload_t(sma_pkg::rsp_t)) rsp_if ();

	alloc_tracker tracker;
	// Chances, in percent per cycle, that the sender holds back an item and
	// that the receiver refuses a result.
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	size_match_reuse_allocator #(.TABLE_ENTRIES(TABLE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Allocate and free requests. The field that a command ignores is filled
	// with random bits so that it is seen to have no effect.
	function automatic sma_pkg::req_t alloc_of(logic [sma_pkg::SizeW-1:0] sz);
		sma_pkg::req_t r;
		r.cmd = sma_pkg::CmdAlloc;
		r.request_size = sz;
		r.free_address = $urandom;
		return r;
	endfunction

	function automatic sma_pkg::req_t free_of(logic [sma_pkg::AddrW-1:0] addr);
		sma_pkg::req_t r;
		r.cmd = sma_pkg::CmdFree;
		r.request_size = sma_pkg::SizeW'($urandom);
		r.free_address = addr;
		return r;
	endfunction

	// Most random requests are allocations from a small set of sizes, so that
	// freed blocks are found again, and frees of addresses that really are in
	// the table. The rest are odd sizes and frees of unknown addresses.
	function automatic sma_pkg::req_t random_request();
		int pick;
		logic [sma_pkg::SizeW-1:0] sz;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 7))
			0: sz = 24'd0;
			1: sz = 24'd1;
			2: sz = 24'd2;
			3: sz = 24'd3;
			4: sz = 24'd8;
			5: sz = 24'd64;
			6: sz = 24'd256;
			default: sz = 24'd4096;
		endcase
		if (pick < 45) return alloc_of(sz);
		if (pick < 52) return alloc_of(sma_pkg::SizeW'($urandom));
		if (pick < 92) return free_of(tracker.pick_address());
		return free_of($urandom);
	endfunction

	// Offers one item and returns in the time step where it is accepted,
	// with valid still high, so that the caller can follow with the next item
	// or lower valid without a second assignment in that step.
	task automatic send_item(sma_pkg::req_t item);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= item;
		do @(posedge clk); while (!req_if.ready);
		tracker.note_request(item);
	endtask

	// Waits until every expected result has come back. Every request yields a
	// result, so once the queue is empty the block is idle and the registers
	// may be written.
	task automatic drain_results(int settle);
		req_if.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Writes both registers one after the other, base first.
	task automatic program_heap(logic [sma_pkg::AddrW-1:0] base,
			logic [sma_pkg::SizeW-1:0] limit);
		cfg_we <= 1'b1;
		cfg_index <= sma_pkg::CfgHeapBase;
		cfg_data <= base;
		@(posedge clk);
		tracker.write_reg(sma_pkg::CfgHeapBase, base);
		cfg_index <= sma_pkg::CfgHeapLimit;
		cfg_data <= {8'd0, limit};
		@(posedge clk);
		tracker.write_reg(sma_pkg::CfgHeapLimit, {8'd0, limit});
		cfg_we <= 1'b0;
	endtask

	// The receiver side: every accepted result is checked against the oldest
	// expectation, and ready is redrawn for the next cycle.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) tracker.check_response(rsp_if.data);
			rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// The watchdog ends a run in which nothing has moved for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_size_match_reuse_allocator failed");
		$finish;
	end

	initial begin
		logic [sma_pkg::AddrW-1:0] base;
		logic [sma_pkg::SizeW-1:0] limit;
		int phase_idle;
		int phase_stall;
		tracker = new();
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sma_pkg::CfgHeapBase;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The base is set near the top of the address space while the table is
		// still empty, so the pointer moves with it and will wrap later. A zero
		// limit leaves room for zero-size blocks only.
		program_heap(32'hFFFF_FFF0, 24'd0);
		send_item(free_of(32'h1234_5678));      // empty table: not found
		send_item(alloc_of(24'd0));             // zero size fits a zero limit
		send_item(alloc_of(24'd1));             // heap full
		send_item(alloc_of(24'hFF_FFFF));       // heap full at the largest size
		send_item(alloc_of(24'd0));             // second block at the same address
		send_item(free_of(32'hFFFF_FFF0));      // the lower of the two is released
		send_item(alloc_of(24'd0));             // and is handed out again
		send_item(free_of(32'h0000_0000));      // not found
		drain_results(4);

		// With blocks in the table a new base leaves the bump pointer where it is.
		program_heap(32'h0000_0000, 24'hFF_FFFF);
		send_item(alloc_of(24'h20));            // the pointer wraps past zero
		send_item(alloc_of(24'd5));
		send_item(free_of(32'h0000_0010));
		send_item(free_of(32'h0000_0010));      // freeing a free block is fine
		send_item(alloc_of(24'd5));             // reused
		send_item(free_of(32'hFFFF_FFFF));      // not found
		send_item(alloc_of(24'hFF_FFFF));       // heap full
		drain_results(4);

		// A limit below what is already used refuses fresh blocks but not reuse.
		program_heap(32'hFFFF_FFFF, 24'h10);
		send_item(free_of(32'h0000_0010));
		send_item(alloc_of(24'd5));             // reused despite the limit
		send_item(alloc_of(24'd7));             // heap full
		send_item(alloc_of(24'd0));             // heap full even at zero size
		drain_results(4);

		// A limit equal to the use still admits a zero-size block.
		program_heap(32'h8000_0000, tracker.heap_used);
		send_item(alloc_of(24'd0));
		send_item(alloc_of(24'd1));             // heap full
		drain_results(4);

		// Random phases, each of which sets the registers and an idling pattern.
		// The table soon fills, after which fresh blocks that pass the heap check
		// meet the table-full refusal and only reuse and frees change anything.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin base = $urandom; limit = 24'hFF_FFFF; end
				1: begin
					base = 32'hFFFF_FFFF;
					limit = sma_pkg::SizeW'($urandom_range(0, 24'hFFFF));
				end
				2: begin base = 32'h0000_0000; limit = 24'd0; end
				3: begin base = $urandom; limit = tracker.heap_used; end
				4: begin base = $urandom; limit = sma_pkg::SizeW'($urandom); end
				default: begin base = $urandom; limit = 24'hFF_FFFF; end
			endcase
			program_heap(base, limit);
			case (phase % 4)
				0: begin phase_idle = 0; phase_stall = 0; end
				1: begin phase_idle = 67; phase_stall = 0; end
				2: begin phase_idle = 0; phase_stall = 67; end
				default: begin phase_idle = 29; phase_stall = 29; end
			endcase
			// Stretches of up to a few dozen items go by without any idling.
			for (int n = 0; n < 300; n++) begin
				if (n % 64 >= 40) begin
					idle_pct = 0;
					stall_pct = 0;
				end else begin
					idle_pct = phase_idle;
					stall_pct = phase_stall;
				end
				send_item(random_request());
			end
			drain_results(4);
		end

		drain_results(DRAIN_CYCLES);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb_size_match_reuse_allocator passed");
		end else begin
			$display("tb_size_match_reuse_allocator failed");
		end
		$finish;
	end

endmodule
